[src/qbs_pkg.sv]
// Shared types and character codes for the query bracket splitter.
package qbs_pkg;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [15:0] FIRST_LINE_RST = 16'd1;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_QUOTE = 2'd1,
    MARK_PAREN = 2'd2,
    MARK_BRACE = 2'd3
  } mark_t;

  typedef enum logic [2:0] {
    ST_CONT = 3'd0,
    ST_DONE = 3'd1,
    ST_ERR  = 3'd2,
    ST_EOI  = 3'd3,
    ST_OVF  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    mark_t mark;
  } stack_op_t;

  typedef struct packed {
    logic  empty;
    logic  one;
    logic  full;
    mark_t top;
  } stack_stat_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        keep;
    logic        withdraw_previous;
    status_t     status;
    logic [15:0] line_number;
    logic [15:0] column;
  } result_t;

endpackage

[src/query_bracket_splitter.sv]
// Query bracket splitter: splits a byte stream into queries, checks nesting.
//
// Input channel (in_valid / in_stall): one byte or end-of-input marker per
// transfer. Result channel (out_valid / out_stall): exactly one result per
// input transfer, in order, telling whether the byte is kept, whether the
// previously kept byte is withdrawn, the query status and line/column.
// Each result is registered in the output stage, or in the skid buffer.
// Throughput: one transfer per cycle unless in_stall is high; the nesting
// stack keeps its top and the entry below it in registers, so a push or pop
// never waits for the memory. Output register plus a one-entry skid buffer:
// while a result waits under out_stall, one more input is taken; in_stall
// rises only when both are full and is driven from a register.
// cfg_wr_en / cfg_wr_data write first_line; reset returns first_line to 1
// and loads the line counter from it, so the counter always starts at 1.
// Reset (rst_n low, synchronous) empties the stack, clears comment state,
// column and both output stages; no clearing pass is needed.
module query_bracket_splitter
  import qbs_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_out,
  output logic        out_keep,
  output logic        out_withdraw_previous,
  output logic [2:0]  out_status,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] first_line_r;
  logic [15:0] first_line_nxt;
  logic        in_comment_r;
  logic        in_comment_nxt;
  logic [7:0]  prev_r;
  logic [7:0]  prev_nxt;
  logic [15:0] line_r;
  logic [15:0] line_nxt;
  logic [15:0] col_r;
  logic [15:0] col_nxt;
  logic        accept;
  logic        out_fire;
  result_t     res;
  result_t     out_r;
  result_t     skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  stack_op_t   sop;
  stack_stat_t sst;

  qbs_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .op   (sop),
    .stat (sst)
  );

  assign accept   = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign first_line_nxt = !rst_n    ? FIRST_LINE_RST :
                          cfg_wr_en ? cfg_wr_data    : first_line_r;

  always_ff @(posedge clk) begin
    first_line_r <= first_line_nxt;
  end

  always_comb begin
    logic [7:0]  c;
    logic [15:0] col_inc;
    logic        restart;
    logic        top_quote;
    logic        depth_zero_after;
    c                = in_byte_value;
    col_inc          = (col_r == 16'hFFFF) ? col_r : col_r + 16'd1;
    restart          = 1'b0;
    top_quote        = !sst.empty && (sst.top == MARK_QUOTE);
    depth_zero_after = 1'b0;
    res              = '0;
    res.status       = ST_CONT;
    sop              = '0;
    sop.mark         = MARK_NONE;
    in_comment_nxt   = in_comment_r;
    prev_nxt         = prev_r;
    line_nxt         = line_r;
    col_nxt          = col_r;

    if (in_kind == KIND_END) begin
      res.status = sst.empty ? ST_EOI : ST_ERR;
      restart    = 1'b1;
    end else if (c != CH_CR) begin
      if (!in_comment_r) begin
        res.keep     = 1'b1;
        res.char_out = c;
        col_nxt      = col_inc;
        if (c == CH_DASH && prev_r == CH_DASH) begin
          res.keep              = 1'b0;
          res.char_out          = '0;
          res.withdraw_previous = 1'b1;
          col_nxt               = (col_inc >= 16'd2) ? col_inc - 16'd2 : 16'd0;
          in_comment_nxt        = 1'b1;
        end else if (top_quote) begin
          sop.pop = (c == CH_QUOTE);
        end else if (c == CH_QUOTE || c == CH_LPAREN || c == CH_LBRACE) begin
          if (sst.full) begin
            res.status = ST_OVF;
          end else begin
            sop.push = 1'b1;
            sop.mark = (c == CH_QUOTE)  ? MARK_QUOTE :
                       (c == CH_LPAREN) ? MARK_PAREN : MARK_BRACE;
          end
        end else if (c == CH_RPAREN || c == CH_RBRACE) begin
          if (sst.empty ||
              sst.top != ((c == CH_RPAREN) ? MARK_PAREN : MARK_BRACE)) begin
            res.status = ST_ERR;
          end else begin
            sop.pop = 1'b1;
          end
        end
        if (res.status != ST_CONT) begin
          res.keep     = 1'b0;
          res.char_out = '0;
          restart      = 1'b1;
        end
      end

      depth_zero_after = (sst.empty && !sop.push) || (sst.one && sop.pop);
      if (res.status == ST_CONT && c == CH_LF) begin
        line_nxt = line_r + 16'd1;
        col_nxt  = '0;
        if (prev_r == CH_BSLASH) begin
          res.keep     = 1'b0;
          res.char_out = '0;
        end else if (depth_zero_after) begin
          res.keep     = 1'b1;
          res.char_out = CH_LF;
          res.status   = ST_DONE;
          restart      = 1'b1;
        end else begin
          in_comment_nxt = 1'b0;
        end
      end
      prev_nxt = c;
    end

    res.line_number = line_nxt;
    res.column      = col_nxt;

    // start a new query after any final status
    if (restart) begin
      sop.clear      = 1'b1;
      in_comment_nxt = 1'b0;
      prev_nxt       = '0;
      col_nxt        = '0;
    end

    // no state moves without a transfer
    if (!accept) begin
      sop            = '0;
      sop.mark       = MARK_NONE;
      in_comment_nxt = in_comment_r;
      prev_nxt       = prev_r;
      line_nxt       = line_r;
      col_nxt        = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      prev_r       <= '0;
      line_r       <= first_line_nxt;
      col_r        <= '0;
    end else begin
      in_comment_r <= in_comment_nxt;
      prev_r       <= prev_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (accept && out_valid_r && !out_fire) begin
      skid_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_char_out          = out_r.char_out;
  assign out_keep              = out_r.keep;
  assign out_withdraw_previous = out_r.withdraw_previous;
  assign out_status            = out_r.status;
  assign out_line_number       = out_r.line_number;
  assign out_column            = out_r.column;

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled while output was free");

  a_final_drops_byte : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_ERR || out_r.status == ST_OVF ||
                    out_r.status == ST_EOI) |-> !out_r.keep && out_r.column == 16'd0 ||
                    !out_r.keep)
    else $error("byte kept on a failing or end status");
`endif

endmodule

[src/qbs_stack.sv]
// Nesting mark stack: top and next-below in registers, the rest in a memory.
module qbs_stack
  import qbs_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  stack_op_t   op,
  output stack_stat_t stat
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  mark_t         top_r;
  mark_t         below_r;
  mark_t         mem [STACK_DEPTH-1];

  always_comb begin
    if (op.clear) begin
      depth_nxt = '0;
    end else if (op.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (op.pop) begin
      depth_nxt = depth_r - DW'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  assign wr_ptr = AW'(depth_r - DW'(1));
  assign rd_ptr = AW'(depth_nxt - DW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // mem[i] holds stack entry i for every i below depth - 1
  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      top_r <= op.mark;
      if (depth_r != '0) begin
        mem[wr_ptr] <= top_r;
      end
    end else if (op.pop && !op.clear) begin
      top_r <= below_r;
    end
    // keep below_r equal to the entry under the new top
    if (op.push && !op.clear) begin
      below_r <= top_r;
    end else if (depth_nxt >= DW'(2)) begin
      below_r <= mem[rd_ptr];
    end
  end

  assign stat.empty = (depth_r == '0);
  assign stat.one   = (depth_r == DW'(1));
  assign stat.full  = (depth_r == DW'(STACK_DEPTH));
  assign stat.top   = top_r;

endmodule

[tb/tb.sv]
// Testbench for query_bracket_splitter: random query streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import qbs_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 310;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_byte_value = 8'd0;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char_out;
  logic        out_keep;
  logic        out_withdraw_previous;
  logic [2:0]  out_status;
  logic [15:0] out_line_number;
  logic [15:0] out_column;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  query_bracket_splitter #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_kind               (in_kind),
    .in_byte_value         (in_byte_value),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_char_out          (out_char_out),
    .out_keep              (out_keep),
    .out_withdraw_previous (out_withdraw_previous),
    .out_status            (out_status),
    .out_line_number       (out_line_number),
    .out_column            (out_column),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stream_item_t byte_stream[$];
  result_t      expected_results[$];
  int           stream_total = 0;
  int           accepted_count = 0;
  int           checked_count = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  // idle odds are 1 in N; zero means no idling
  int           send_idle_odds = 0;
  int           recv_stall_odds = 0;
  logic         hold_armed = 1'b0;

  // splitter state as the predictor sees it
  mark_t        mark_stack[STACK_DEPTH];
  int           open_marks;
  logic         comment_on;
  logic [7:0]   last_byte;
  logic [15:0]  line_count;
  logic [15:0]  kept_col;

  task automatic split_byte(input kind_t kind, input logic [7:0] c, output result_t res);
    logic       keep;
    logic       wd;
    logic       restart;
    logic [7:0] ch;
    status_t    st;
    mark_t      top;
    mark_t      m;
    keep = 1'b0;
    wd = 1'b0;
    restart = 1'b0;
    ch = 8'd0;
    st = ST_CONT;
    top = (open_marks == 0) ? MARK_NONE : mark_stack[open_marks-1];
    if (kind == KIND_END) begin
      st = (open_marks != 0) ? ST_ERR : ST_EOI;
      restart = 1'b1;
    end else if (c != CH_CR) begin
      if (!comment_on) begin
        keep = 1'b1;
        ch = c;
        if (kept_col != 16'hFFFF) kept_col++;
        if (c == CH_DASH && last_byte == CH_DASH) begin
          // withdraw the first dash, drop this one
          keep = 1'b0;
          ch = 8'd0;
          wd = 1'b1;
          kept_col = (kept_col >= 16'd2) ? kept_col - 16'd2 : 16'd0;
          comment_on = 1'b1;
        end else if (top == MARK_QUOTE) begin
          if (c == CH_QUOTE) open_marks--;
        end else if (c == CH_QUOTE || c == CH_LPAREN || c == CH_LBRACE) begin
          m = (c == CH_QUOTE) ? MARK_QUOTE : (c == CH_LPAREN) ? MARK_PAREN : MARK_BRACE;
          if (open_marks >= STACK_DEPTH) st = ST_OVF;
          else begin
            mark_stack[open_marks] = m;
            open_marks++;
          end
        end else if (c == CH_RPAREN || c == CH_RBRACE) begin
          m = (c == CH_RPAREN) ? MARK_PAREN : MARK_BRACE;
          if (open_marks == 0 || top != m) st = ST_ERR;
          else open_marks--;
        end
        if (st != ST_CONT) begin
          keep = 1'b0;
          ch = 8'd0;
          restart = 1'b1;
        end
      end
      if (st == ST_CONT && c == CH_LF) begin
        line_count = line_count + 16'd1;
        kept_col = 16'd0;
        if (last_byte == CH_BSLASH) begin
          keep = 1'b0;
          ch = 8'd0;
        end else if (open_marks == 0) begin
          keep = 1'b1;
          ch = CH_LF;
          st = ST_DONE;
          restart = 1'b1;
        end else begin
          comment_on = 1'b0;
        end
      end
      last_byte = c;
    end
    res.char_out = ch;
    res.keep = keep;
    res.withdraw_previous = wd;
    res.status = st;
    res.line_number = line_count;
    res.column = kept_col;
    if (restart) begin
      open_marks = 0;
      comment_on = 1'b0;
      last_byte = 8'd0;
      kept_col = 16'd0;
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    stream_item_t it;
    it.kind = KIND_CHAR;
    it.value = c;
    byte_stream.push_back(it);
    stream_total++;
  endtask

  task automatic push_end();
    stream_item_t it;
    it.kind = KIND_END;
    it.value = 8'($urandom_range(0, 255));
    byte_stream.push_back(it);
    stream_total++;
  endtask

  // mostly balanced text; newlines inside nesting keep the query open
  task automatic gen_nested(input int level);
    int         n;
    int         k;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ((level >= 4) ? 0 : $urandom_range(0, 11))
        4: begin
          push_char(CH_LPAREN);
          gen_nested(level + 1);
          push_char(CH_RPAREN);
        end
        5: begin
          push_char(CH_LBRACE);
          gen_nested(level + 1);
          push_char(CH_RBRACE);
        end
        6: begin
          push_char(CH_QUOTE);
          k = $urandom_range(0, 4);
          for (int j = 0; j < k; j++) begin
            b = 8'($urandom_range(8'h20, 8'h7E));
            push_char((b == CH_QUOTE) ? 8'h78 : b);
          end
          if ($urandom_range(0, 9) == 0) begin
            push_char(CH_DASH);
            push_char(CH_DASH);
          end
          push_char(CH_QUOTE);
        end
        7: push_char(CH_CR);
        8: begin
          push_char(CH_BSLASH);
          push_char(CH_LF);
        end
        9: push_char((level > 0) ? CH_LF : 8'h71);
        10: begin
          push_char(CH_DASH);
          push_char(8'($urandom_range(8'h30, 8'h39)));
        end
        default: push_char(($urandom_range(0, 4) == 0) ? 8'h20 :
                           8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end
  endtask

  // sender
  int idle_left = 0;
  always @(posedge clk) begin : send_proc
    result_t      res;
    stream_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
      open_marks = 0;
      comment_on = 1'b0;
      last_byte = 8'd0;
      kept_col = 16'd0;
      line_count = FIRST_LINE_RST;
    end else begin
      if (in_valid && !in_stall) begin
        split_byte(kind_t'(in_kind), in_byte_value, res);
        expected_results.push_back(res);
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
            idle_left = $urandom_range(0, 4);
            in_valid <= 1'b0;
          end else begin
            it = byte_stream.pop_front();
            in_valid <= 1'b1;
            in_kind <= it.kind;
            in_byte_value <= it.value;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: short stall bursts plus the occasional long hold
  logic stall_burst = 1'b0;
  logic long_hold = 1'b0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   next_hold_at = 300;

  assign out_stall = stall_burst | long_hold;

  always @(posedge clk) begin : hold_proc
    if (!rst_n) begin
      long_hold <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      long_hold <= (hold_left != 0);
    end else if (hold_armed && accepted_count >= next_hold_at) begin
      hold_left = $urandom_range(40, 60);
      long_hold <= 1'b1;
      next_hold_at = next_hold_at + 400;
    end
  end

  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst_n) begin
      stall_burst <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked_count <= checked_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: char_out %0h status %0d",
                 out_char_out, out_status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_char_out !== want.char_out) begin
            $error("char_out: expected %0h, got %0h", want.char_out, out_char_out);
            mismatches++;
          end
          if (out_keep !== want.keep) begin
            $error("keep: expected %0d, got %0d", want.keep, out_keep);
            mismatches++;
          end
          if (out_withdraw_previous !== want.withdraw_previous) begin
            $error("withdraw_previous: expected %0d, got %0d",
                   want.withdraw_previous, out_withdraw_previous);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_line_number !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number, out_line_number);
            mismatches++;
          end
          if (out_column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, out_column);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_burst <= 1'b1;
      end else if (recv_stall_odds != 0 && $urandom_range(1, recv_stall_odds) == 1) begin
        stall_left = $urandom_range(0, 4);
        stall_burst <= 1'b1;
      end else begin
        stall_burst <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] first_line_val[4];
    int          target;
    int          n;
    first_line_val[0] = 16'd0;
    first_line_val[1] = 16'hFFFF;
    first_line_val[2] = 16'($urandom_range(2, 65534));
    first_line_val[3] = 16'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= first_line_val[phase];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      send_idle_odds <= (phase == 3) ? 0 : (phase == 2) ? 3 : 8;
      recv_stall_odds <= (phase == 3) ? 0 : (phase == 2) ? 3 : 8;
      hold_armed <= (phase == 1 || phase == 2);

      if (phase == 0) begin
        // mismatched closer, then closer on an empty stack
        push_char(CH_LBRACE);
        push_char(CH_RPAREN);
        push_char(CH_RPAREN);
        // dash pair inside a quote, newline in comment with open nesting
        push_char(CH_LPAREN);
        push_char(CH_QUOTE);
        push_char(CH_RPAREN);
        push_char(CH_DASH);
        push_char(CH_DASH);
        push_char(CH_LF);
        // line continuation, carriage return, then close and complete
        push_char(CH_BSLASH);
        push_char(CH_LF);
        push_char(CH_CR);
        push_char(CH_QUOTE);
        push_char(CH_RPAREN);
        push_char(CH_LF);
        // comment ahead of a completing newline
        push_char(8'h61);
        push_char(CH_DASH);
        push_char(CH_DASH);
        push_char(CH_LF);
        // byte extremes, end of input with and without open nesting
        push_char(8'hFF);
        push_char(8'h00);
        push_char(CH_LPAREN);
        push_end();
        push_end();
      end

      target = stream_total + PHASE_ITEMS;
      while (stream_total < target) begin
        case ($urandom_range(0, 39))
          28, 29, 30, 31: begin
            // opened query: closer of either kind, which may not match, or premature end
            push_char(($urandom_range(0, 1) == 1) ? CH_LPAREN : CH_LBRACE);
            gen_nested(1);
            case ($urandom_range(0, 2))
              0: push_char(CH_RPAREN);
              1: push_char(CH_RBRACE);
              default: push_end();
            endcase
          end
          32, 33, 34, 35: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
          end
          36: begin
            // deep nesting up to and past the stack limit
            n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2);
            for (int i = 0; i < n; i++) push_char(CH_LPAREN);
            if (n <= STACK_DEPTH)
              for (int i = 0; i < n; i++) push_char(CH_RPAREN);
            push_char(CH_LF);
          end
          37, 38: push_end();
          default: begin
            gen_nested(0);
            case ($urandom_range(0, 9))
              6, 7: begin
                push_char(CH_DASH);
                push_char(CH_DASH);
                push_char(8'($urandom_range(8'h20, 8'h7E)));
                push_char(CH_LF);
              end
              8: begin
                push_char(CH_BSLASH);
                push_char(CH_LF);
                push_char(CH_LF);
              end
              9: begin
                push_char(CH_CR);
                push_char(CH_LF);
              end
              default: push_char(CH_LF);
            endcase
          end
        endcase
      end

      // drain before the next register write
      while (accepted_count != stream_total || checked_count != stream_total)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
src/qbs_pkg.sv
src/qbs_stack.sv
src/query_bracket_splitter.sv
tb/tb.sv
